// File: rtl/core/smu_pkg.sv
// Package for the stack machine unit: sizes, operation and status codes,
// payload structs and the controller/datapath command struct. No dependencies.
`default_nettype none
package smu_pkg;
  localparam int unsigned StackDepth = 2048;
  localparam int unsigned WordWidth  = 32;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned CountW     = $clog2(StackDepth + 1);

  localparam logic [CountW-1:0] FullCount = CountW'(StackDepth);

  localparam logic [3:0] FnPush = 4'd0;
  localparam logic [3:0] FnPop  = 4'd1;
  localparam logic [3:0] FnPeek = 4'd2;
  localparam logic [3:0] FnDup  = 4'd3;
  localparam logic [3:0] FnCopy = 4'd4;
  localparam logic [3:0] FnSwap = 4'd5;
  localparam logic [3:0] FnDisc = 4'd6;
  localparam logic [3:0] FnAdd  = 4'd7;
  localparam logic [3:0] FnSub  = 4'd8;
  localparam logic [3:0] FnMul  = 4'd9;
  localparam logic [3:0] FnDiv  = 4'd10;
  localparam logic [3:0] FnMod  = 4'd11;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StUnder = 2'd1;
  localparam logic [1:0] StOver  = 2'd2;
  localparam logic [1:0] StDivZ  = 2'd3;

  typedef struct packed {
    logic [3:0]                  func;
    logic signed [WordWidth-1:0] push_value;
    logic [AddrW-1:0]            depth_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [WordWidth-1:0] read_value;
    logic [CountW-1:0]           item_count;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             load_in;   // capture input item
    logic             rd_en;     // issue memory read
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [1:0]       wr_sel;    // 0 push value, 1 read data, 2 saved b, 3 alu
    logic             save_b;    // latch read data as b (top)
    logic             save_a;    // latch read data as a (second)
    logic             alu_go;    // start arithmetic
    logic             set_top;   // latch read data as reported top
    logic             top_alu;   // take reported top from alu result
    logic             top_b;     // take reported top from saved b
    logic             top_zero;
  } smu_cmd_t;

  typedef struct packed {
    logic             alu_done;
  } smu_sts_t;

  localparam logic [1:0] WsPush = 2'd0;
  localparam logic [1:0] WsRd   = 2'd1;
  localparam logic [1:0] WsB    = 2'd2;
  localparam logic [1:0] WsAlu  = 2'd3;
endpackage
`default_nettype wire

// File: rtl/core/smu_div.sv
// Iterative signed divider, one quotient bit per cycle.
// Depends on smu_pkg for the word width.
`default_nettype none
module smu_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [smu_pkg::WordWidth-1:0] a_i,
  input  wire logic [smu_pkg::WordWidth-1:0] b_i,
  output logic                               done_o,
  output logic [smu_pkg::WordWidth-1:0]      quot_o,
  output logic [smu_pkg::WordWidth-1:0]      rem_o
);
  localparam int unsigned W  = smu_pkg::WordWidth;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_q, q_d, r_q, r_d, d_q, d_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d, qn_q, qn_d, rn_q, rn_d;
  logic [W:0]    trial;

  always_comb begin
    q_d = q_q; r_d = r_q; d_d = d_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0; qn_d = qn_q; rn_d = rn_q;
    trial = {r_q, q_q[W-1]} - {1'b0, d_q};
    if (start_i) begin
      q_d = a_i[W-1] ? (~a_i + 1'b1) : a_i;
      d_d = b_i[W-1] ? (~b_i + 1'b1) : b_i;
      r_d = '0;
      qn_d = a_i[W-1] ^ b_i[W-1];
      rn_d = a_i[W-1];
      cnt_d = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        r_d = trial[W-1:0];
        q_d = {q_q[W-2:0], 1'b1};
      end else begin
        r_d = {r_q[W-2:0], q_q[W-1]};
        q_d = {q_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; d_q <= d_d; qn_q <= qn_d; rn_q <= rn_d;
  end

  assign done_o = done_q;
  assign quot_o = qn_q ? (~q_q + 1'b1) : q_q;
  assign rem_o  = rn_q ? (~r_q + 1'b1) : r_q;
endmodule
`default_nettype wire

// File: rtl/core/smu_datapath.sv
// Datapath: stack memory, operand registers, adder, multiplier and divider.
// Depends on smu_pkg and smu_div.
`default_nettype none
module smu_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire smu_pkg::in_item_t in_i,
  input  wire smu_pkg::smu_cmd_t cmd_i,
  output smu_pkg::smu_sts_t      sts_o,
  output smu_pkg::in_item_t      item_o,
  output logic [smu_pkg::WordWidth-1:0] top_o
);
  localparam int unsigned W = smu_pkg::WordWidth;

  logic [W-1:0] mem_q [smu_pkg::StackDepth];
  logic [W-1:0] rd_q, a_q, b_q, top_q, alu_q, wdata, quot, rem;
  logic         div_done;
  logic         alu_pend_q;
  logic [3:0]   fn;
  smu_pkg::in_item_t item_q;

  assign fn = item_q.func;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rd_q <= mem_q[cmd_i.rd_addr];
    if (cmd_i.wr_en) mem_q[cmd_i.wr_addr] <= wdata;
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      smu_pkg::WsPush: wdata = item_q.push_value;
      smu_pkg::WsRd:   wdata = rd_q;
      smu_pkg::WsB:    wdata = b_q;
      default:         wdata = alu_q;
    endcase
  end

  smu_div u_div (
    .clk_i, .rst_ni,
    .start_i (cmd_i.alu_go && (fn == smu_pkg::FnDiv || fn == smu_pkg::FnMod)),
    .a_i (a_q), .b_i (b_q),
    .done_o (div_done), .quot_o (quot), .rem_o (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) alu_pend_q <= 1'b0;
    else alu_pend_q <= cmd_i.alu_go && !(fn == smu_pkg::FnDiv || fn == smu_pkg::FnMod);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) item_q <= in_i;
    if (cmd_i.save_b)  b_q <= rd_q;
    if (cmd_i.save_a)  a_q <= rd_q;
    if (cmd_i.alu_go) begin
      case (fn)
        smu_pkg::FnAdd: alu_q <= a_q + b_q;
        smu_pkg::FnSub: alu_q <= a_q - b_q;
        smu_pkg::FnMul: alu_q <= W'(a_q * b_q);
        default:        alu_q <= alu_q;
      endcase
    end else if (div_done) begin
      alu_q <= (fn == smu_pkg::FnDiv) ? quot : rem;
    end
    if (cmd_i.top_zero)     top_q <= '0;
    else if (cmd_i.set_top) top_q <= rd_q;
    else if (cmd_i.top_alu) top_q <= alu_q;
    else if (cmd_i.top_b)   top_q <= b_q;
  end

  assign sts_o.alu_done = alu_pend_q || div_done;
  assign item_o = item_q;
  assign top_o  = top_q;
endmodule
`default_nettype wire

// File: rtl/core/smu_ctrl.sv
// Controller: sequences memory accesses per operation and owns the count.
// Depends on smu_pkg.
`default_nettype none
module smu_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire smu_pkg::in_item_t item_i,
  input  wire smu_pkg::smu_sts_t sts_i,
  input  wire logic [smu_pkg::WordWidth-1:0] top_i,
  output smu_pkg::smu_cmd_t      cmd_o,
  output smu_pkg::out_item_t     out_o
);
  localparam int unsigned AW = smu_pkg::AddrW;
  localparam int unsigned CW = smu_pkg::CountW;

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SDec  = 4'd1;
  localparam logic [3:0] SRdB  = 4'd2;  // read data for top (b) available
  localparam logic [3:0] SRdA  = 4'd3;  // read data for second (a) available
  localparam logic [3:0] SAlu  = 4'd4;
  localparam logic [3:0] SWait = 4'd5;
  localparam logic [3:0] SWr   = 4'd6;
  localparam logic [3:0] STop  = 4'd7;  // fetch new top
  localparam logic [3:0] STopD = 4'd8;
  localparam logic [3:0] SOut  = 4'd9;
  localparam logic [3:0] SCpy  = 4'd10;
  localparam logic [3:0] SPeek = 4'd11;
  localparam logic [3:0] SSwap = 4'd12;
  localparam logic [3:0] STopR = 4'd13; // fetched top available

  logic [3:0]      state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [1:0]      st_q, st_d;
  logic [CW-1:0]   dep, topi, sec;
  logic            full;

  assign dep  = CW'(item_i.depth_index);
  assign topi = cnt_q - 1'b1;
  assign sec  = cnt_q - CW'(2);
  assign full = (cnt_q == smu_pkg::FullCount);

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; st_d = st_q;
    cmd_o = '0;
    in_ready_o  = (state_q == SIdle);
    out_valid_o = (state_q == SOut);
    unique case (state_q)
      SIdle: if (in_valid_i) begin
        cmd_o.load_in = 1'b1;
        state_d = SDec;
        st_d = smu_pkg::StOk;
      end
      SDec: begin
        state_d = STop;
        case (item_i.func)
          smu_pkg::FnPush: begin
            if (full) st_d = smu_pkg::StOver;
            else begin
              cmd_o.wr_en = 1'b1; cmd_o.wr_addr = AW'(cnt_q);
              cmd_o.wr_sel = smu_pkg::WsPush; cnt_d = cnt_q + 1'b1;
            end
          end
          smu_pkg::FnPop: begin
            if (cnt_q == '0) st_d = smu_pkg::StUnder;
            else begin
              cmd_o.rd_en = 1'b1; cmd_o.rd_addr = AW'(topi);
              cnt_d = topi; state_d = SPeek;
            end
          end
          smu_pkg::FnPeek: begin
            if (dep >= cnt_q) st_d = smu_pkg::StUnder;
            else begin
              cmd_o.rd_en = 1'b1; cmd_o.rd_addr = AW'(topi - dep);
              state_d = SPeek;
            end
          end
          smu_pkg::FnDup, smu_pkg::FnCopy: begin
            if ((item_i.func == smu_pkg::FnDup ? CW'(0) : dep) >= cnt_q)
              st_d = smu_pkg::StUnder;
            else if (full) st_d = smu_pkg::StOver;
            else begin
              cmd_o.rd_en = 1'b1;
              cmd_o.rd_addr = AW'(topi -
                                  (item_i.func == smu_pkg::FnDup ? CW'(0) : dep));
              state_d = SCpy;
            end
          end
          smu_pkg::FnDisc: begin
            if (cnt_q == '0) st_d = smu_pkg::StUnder;
            else cnt_d = topi;
          end
          smu_pkg::FnSwap, smu_pkg::FnAdd, smu_pkg::FnSub, smu_pkg::FnMul,
          smu_pkg::FnDiv, smu_pkg::FnMod: begin
            if (cnt_q < CW'(2)) st_d = smu_pkg::StUnder;
            else begin
              cmd_o.rd_en = 1'b1; cmd_o.rd_addr = AW'(topi);
              state_d = SRdB;
            end
          end
          default: ;
        endcase
      end
      // The popped or peeked word becomes the reported value.
      SPeek: begin
        cmd_o.set_top = 1'b1; state_d = SOut;
      end
      SCpy: begin
        cmd_o.wr_en = 1'b1; cmd_o.wr_addr = AW'(cnt_q);
        cmd_o.wr_sel = smu_pkg::WsRd; cnt_d = cnt_q + 1'b1;
        cmd_o.set_top = 1'b1; state_d = SOut;
      end
      SRdB: begin
        cmd_o.save_b = 1'b1;
        cmd_o.rd_en = 1'b1; cmd_o.rd_addr = AW'(sec);
        state_d = SRdA;
      end
      SRdA: begin
        cmd_o.save_a = 1'b1;
        if (item_i.func == smu_pkg::FnSwap) begin
          // Old second goes to top; old top is written to second next.
          cmd_o.wr_en = 1'b1; cmd_o.wr_addr = AW'(topi);
          cmd_o.wr_sel = smu_pkg::WsRd; cmd_o.set_top = 1'b1;
          state_d = SSwap;
        end else state_d = SAlu;
      end
      SSwap: begin
        cmd_o.wr_en = 1'b1; cmd_o.wr_addr = AW'(sec);
        cmd_o.wr_sel = smu_pkg::WsB; state_d = SOut;
      end
      // The divisor is moved to the reported top so it can be tested next.
      SAlu: begin
        cmd_o.top_b = 1'b1;
        state_d = SWait;
      end
      SWait: begin
        if (top_i == '0 &&
            (item_i.func == smu_pkg::FnDiv || item_i.func == smu_pkg::FnMod)) begin
          st_d = smu_pkg::StDivZ;
          state_d = SOut;   // stack unchanged, top is b (zero)
        end else begin
          cmd_o.alu_go = 1'b1;
          state_d = SWr;
        end
      end
      SWr: if (sts_i.alu_done) begin
        state_d = STopD;
      end
      STopD: begin
        cmd_o.wr_en = 1'b1; cmd_o.wr_addr = AW'(sec);
        cmd_o.wr_sel = smu_pkg::WsAlu; cmd_o.top_alu = 1'b1;
        cnt_d = topi; state_d = SOut;
      end
      STop: begin
        if (cnt_q == '0) begin
          cmd_o.top_zero = 1'b1; state_d = SOut;
        end else begin
          cmd_o.rd_en = 1'b1; cmd_o.rd_addr = AW'(topi);
          state_d = STopR;
        end
      end
      STopR: begin
        cmd_o.set_top = 1'b1;
        state_d = SOut;
      end
      SOut: if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; cnt_q <= '0; st_q <= smu_pkg::StOk;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; st_q <= st_d;
    end
  end

  assign out_o.status     = st_q;
  assign out_o.read_value = top_i;
  assign out_o.item_count = cnt_q;
endmodule
`default_nettype wire

// File: rtl/core/stack_machine_unit.sv
// Top level of the stack machine unit: controller plus datapath.
// Depends on smu_pkg, smu_ctrl, smu_datapath and smu_div.
//
//   Port group   Direction  Payload
//   in_*         in         in_item_t  (func, push_value, depth_index)
//   out_*        out        out_item_t (status, read_value, item_count)
//
// One item at a time. Div and mod wait on the 32-step divider; a zero divisor
// ends the operation before the divider is started.
// The stack memory has one read and one write port, so reads are serialized.
// Reset empties the stack; memory contents need no clearing.
// A stalled output holds the block until the result is taken.
`default_nettype none
module stack_machine_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire smu_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output smu_pkg::out_item_t      out_data_o
);
  smu_pkg::smu_cmd_t cmd;
  smu_pkg::smu_sts_t sts;
  smu_pkg::in_item_t item;
  logic [smu_pkg::WordWidth-1:0] top;

  smu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .item_i (item), .sts_i (sts), .top_i (top),
    .cmd_o (cmd), .out_o (out_data_o)
  );

  smu_datapath u_dp (
    .clk_i, .rst_ni, .in_i (in_data_i), .cmd_i (cmd),
    .sts_o (sts), .item_o (item), .top_o (top)
  );
endmodule
`default_nettype wire

// File: rtl/core/smu_checker.sv
// Port-level checker for stack_machine_unit, bound to the top level.
// Depends on smu_pkg.
`default_nettype none
module smu_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire smu_pkg::out_item_t out_data_o
);
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.item_count <= smu_pkg::FullCount)
    else $error("count above depth");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken with result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while busy");
  // A failed operation on an empty stack reports a zero top.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.item_count == '0 && out_data_o.status != smu_pkg::StOk
    |-> out_data_o.read_value == '0)
    else $error("nonzero value reported for an empty stack");
endmodule

bind stack_machine_unit smu_checker u_smu_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
`default_nettype wire

// File: tb/sv/stack_machine_unit_test.sv
// Testbench for the stack machine unit: random and directed stack operations
// checked against a behavioral stack model. Depends on smu_pkg and the RTL.
`default_nettype none
module stack_machine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Behavioral operand stack that predicts each result item in order.
  class stack_scoreboard;
    logic [31:0] words[smu_pkg::StackDepth];
    int unsigned depth_used;
    smu_pkg::out_item_t pending[$];
    int unsigned mismatches;
    int unsigned checked;

    function void clear();
      depth_used = 0;
      pending.delete();
      mismatches = 0;
      checked = 0;
    endfunction

    function logic [31:0] top_word();
      return (depth_used == 0) ? 32'd0 : words[depth_used-1];
    endfunction

    function logic [31:0] arith(logic [3:0] fn, logic [31:0] a, logic [31:0] b);
      logic [31:0] ua, ub, r;
      ua = a[31] ? -a : a;
      ub = b[31] ? -b : b;
      r = '0;
      case (fn)
        smu_pkg::FnAdd: r = a + b;
        smu_pkg::FnSub: r = a - b;
        smu_pkg::FnMul: r = a * b;
        smu_pkg::FnDiv: begin
          r = ua / ub;
          if (a[31] != b[31]) r = -r;
        end
        default: begin
          r = ua % ub;
          if (a[31]) r = -r;
        end
      endcase
      return r;
    endfunction

    function void note_input(smu_pkg::in_item_t it);
      smu_pkg::out_item_t o;
      logic [31:0] rv, tmp;
      bit have_read;
      int unsigned d;
      o.status = smu_pkg::StOk;
      have_read = 0;
      rv = '0;
      case (it.func)
        smu_pkg::FnPush: begin
          if (depth_used >= smu_pkg::StackDepth) o.status = smu_pkg::StOver;
          else begin
            words[depth_used] = it.push_value;
            depth_used++;
          end
        end
        smu_pkg::FnPop: begin
          if (depth_used == 0) o.status = smu_pkg::StUnder;
          else begin
            depth_used--;
            rv = words[depth_used];
            have_read = 1;
          end
        end
        smu_pkg::FnPeek: begin
          if (it.depth_index >= depth_used) o.status = smu_pkg::StUnder;
          else begin
            rv = words[depth_used-1-it.depth_index];
            have_read = 1;
          end
        end
        smu_pkg::FnDup, smu_pkg::FnCopy: begin
          d = (it.func == smu_pkg::FnDup) ? 0 : it.depth_index;
          if (d >= depth_used) o.status = smu_pkg::StUnder;
          else if (depth_used >= smu_pkg::StackDepth) o.status = smu_pkg::StOver;
          else begin
            words[depth_used] = words[depth_used-1-d];
            depth_used++;
          end
        end
        smu_pkg::FnSwap: begin
          if (depth_used < 2) o.status = smu_pkg::StUnder;
          else begin
            tmp = words[depth_used-1];
            words[depth_used-1] = words[depth_used-2];
            words[depth_used-2] = tmp;
          end
        end
        smu_pkg::FnDisc: begin
          if (depth_used == 0) o.status = smu_pkg::StUnder;
          else depth_used--;
        end
        smu_pkg::FnAdd, smu_pkg::FnSub, smu_pkg::FnMul, smu_pkg::FnDiv,
        smu_pkg::FnMod: begin
          if (depth_used < 2) o.status = smu_pkg::StUnder;
          else if ((it.func == smu_pkg::FnDiv || it.func == smu_pkg::FnMod) &&
                   words[depth_used-1] == 0)
            o.status = smu_pkg::StDivZ;
          else begin
            tmp = arith(it.func, words[depth_used-2], words[depth_used-1]);
            depth_used--;
            words[depth_used-1] = tmp;
          end
        end
        default: ;
      endcase
      o.read_value = have_read ? rv : top_word();
      o.item_count = depth_used[11:0];
      pending.push_back(o);
    endfunction

    function void check_result(smu_pkg::out_item_t got);
      smu_pkg::out_item_t exp_item;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
        return;
      end
      exp_item = pending.pop_front();
      if (got.status !== exp_item.status || got.read_value !== exp_item.read_value ||
          got.item_count !== exp_item.item_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected st=%0d val=%0d cnt=%0d, got st=%0d val=%0d cnt=%0d",
                   exp_item.status, exp_item.read_value, exp_item.item_count,
                   got.status, got.read_value, got.item_count);
      end
    endfunction
  endclass

  localparam int unsigned StallLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  smu_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  smu_pkg::out_item_t out_data;

  stack_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned op_hits[16];

  stack_machine_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample at the rising edge; the receiver's ready changes at the falling edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no handshake for %0d cycles", StallLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Valid stays high after an accept until the next item or an idle cycle replaces it.
  task automatic send_item(logic [3:0] fn, logic [31:0] val, logic [10:0] depth);
    smu_pkg::in_item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    it.func = fn;
    it.push_value = val;
    it.depth_index = depth;
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    op_hits[fn]++;
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [10:0] rand_depth();
    int unsigned n;
    n = sb.depth_used;
    if ($urandom_range(9) == 0) return 11'($urandom);
    if (n == 0 || $urandom_range(7) == 0) return 11'(n);
    return 11'($urandom_range(n - 1));
  endfunction

  task automatic random_phase(int unsigned count);
    logic [3:0] fn;
    repeat (count) begin
      fn = (sb.depth_used < 2 && $urandom_range(2) != 0) ? smu_pkg::FnPush :
           (sb.depth_used > 40 && $urandom_range(2) == 0) ? smu_pkg::FnDisc :
           4'($urandom_range(15));
      send_item(fn, rand_word(), rand_depth());
    end
  endtask

  initial begin
    sb.clear();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed: underflows on an empty stack, edge values, divide corner cases.
    send_item(smu_pkg::FnPop, '0, '0);
    send_item(smu_pkg::FnPeek, '0, '0);
    send_item(smu_pkg::FnDup, '0, '0);
    send_item(smu_pkg::FnCopy, '0, '0);
    send_item(smu_pkg::FnDisc, '0, '0);
    send_item(smu_pkg::FnSwap, '0, '0);
    send_item(smu_pkg::FnAdd, '0, '0);
    send_item(smu_pkg::FnPush, 32'h8000_0000, 11'h7ff);
    send_item(smu_pkg::FnMul, '0, '0);
    send_item(smu_pkg::FnPush, 32'hffff_ffff, '0);
    send_item(smu_pkg::FnPeek, '0, 11'd1);
    send_item(smu_pkg::FnPeek, '0, 11'd2);
    send_item(smu_pkg::FnCopy, '0, 11'd1);
    send_item(smu_pkg::FnDiv, '0, '0);
    send_item(smu_pkg::FnPush, 32'hffff_ffff, '0);
    send_item(smu_pkg::FnMod, '0, '0);
    send_item(smu_pkg::FnPush, '0, '0);
    send_item(smu_pkg::FnDiv, '0, '0);
    send_item(smu_pkg::FnMod, '0, '0);
    send_item(smu_pkg::FnPush, 32'h7fff_ffff, '0);
    send_item(smu_pkg::FnSwap, '0, '0);
    send_item(smu_pkg::FnSub, '0, '0);
    send_item(4'd12, 32'h5555_aaaa, '0);
    send_item(4'd15, '0, '0);
    // Most negative value divided by minus one wraps.
    send_item(smu_pkg::FnPush, 32'h8000_0000, '0);
    send_item(smu_pkg::FnPush, 32'hffff_ffff, '0);
    send_item(smu_pkg::FnDiv, '0, '0);
    drain();

    send_idle_pct = 20; recv_idle_pct = 58;
    random_phase(341);
    drain();
    send_idle_pct = 58; recv_idle_pct = 20;
    random_phase(341);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(341);

    drain();
    repeat (50) @(negedge clk);
    $display("ran %0d items (%0d checked): directed corners, then random ops", sent,
             sb.checked);
    $display("under both stall patterns and none; push %0d div %0d mod %0d",
             op_hits[smu_pkg::FnPush], op_hits[smu_pkg::FnDiv], op_hits[smu_pkg::FnMod]);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
